/* src/assert_macros.svh */
// Assertion macros shared by the generator's RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* src/msw_pkg.sv */
// Types and constants of the middle-square Weyl generator.
`default_nettype none
package msw_pkg;

  localparam int HALF_W          = 32;
  localparam int STATE_W         = 64;
  localparam int VALUE_W         = 31;
  localparam int DIV_BITS        = 4;
  localparam int DIV_STEPS       = STATE_W / DIV_BITS;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [STATE_W-1:0] WEYL_STEP = 64'hb5ad4eceda1ce2a9;

  typedef enum logic [1:0] {
    OP_SEED     = 2'd0,
    OP_DRAW     = 2'd1,
    OP_DRAW_ERR = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HALF_W-1:0] operand;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_MUL_LO = 3'd1,
    B_MUL_HI = 3'd2,
    B_SUM    = 3'd3,
    B_DIV    = 3'd4,
    B_OUT    = 3'd5
  } back_state_t;

  function automatic logic [STATE_W-1:0] swap_halves(input logic [STATE_W-1:0] x);
    return {x[HALF_W-1:0], x[STATE_W-1:HALF_W]};
  endfunction

endpackage
`default_nettype wire

/* src/msw_front.sv */
// Input stage: accept items, classify them as seed, draw or bad-range draw.
`default_nettype none
module msw_front
  import msw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [2*HALF_W-1:0] s_tdata,   // seed_value, range_limit
  input  wire logic                s_tuser,   // mode
  output logic                     push_valid,
  input  wire logic                push_ready,
  output item_t                    push_item
);

  logic              slot_valid;
  item_t             slot;
  item_t             slot_next;
  logic [HALF_W-1:0] seed_in;
  logic [HALF_W-1:0] range_in;

  assign seed_in  = s_tdata[HALF_W-1:0];
  assign range_in = s_tdata[2*HALF_W-1:HALF_W];

  always_comb begin
    slot_next.operand = seed_in;
    slot_next.op      = OP_SEED;
    if (s_tuser) begin
      slot_next.operand = range_in;
      if (range_in[HALF_W-1] || (range_in == '0)) begin
        slot_next.op = OP_DRAW_ERR;
      end else begin
        slot_next.op = OP_DRAW;
      end
    end
  end

  assign s_tready   = !slot_valid || push_ready;
  assign push_valid = slot_valid;
  assign push_item  = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      slot_valid <= 1'b1;
    end else if (push_ready) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      slot <= slot_next;
    end
  end

endmodule
`default_nettype wire

/* src/msw_queue.sv */
// Short queue of classified items between front and back.
`default_nettype none
`include "assert_macros.svh"
module msw_queue
  import msw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop,
  output item_t      pop_item
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  item_t             entries [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `ASSERT_NEVER(a_queue_overfill, clk, rst, count > CNT_W'(DEPTH))

endmodule
`default_nettype wire

/* src/msw_back.sv */
// Execution unit: seed load, shared-multiplier square, Weyl add, radix-16 remainder.
`default_nettype none
`include "assert_macros.svh"
module msw_back
  import msw_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output logic               pop,
  input  wire item_t         pop_item,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [HALF_W-1:0]  m_tdata,   // value, zero pad bit
  output logic               m_tuser    // range_error
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  back_state_t        state;
  back_state_t        state_next;
  logic [STATE_W-1:0] square_state;
  logic [STATE_W-1:0] weyl_counter;
  logic [STATE_W-1:0] lo_prod;
  logic [VALUE_W-1:0] cross_prod;
  logic [STATE_W-1:0] sum_next;
  logic [STATE_W-1:0] dividend;
  logic [VALUE_W-1:0] divisor;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] rem_next;
  logic [CNT_W-1:0]   div_cnt;
  logic               bad_range;
  logic [VALUE_W-1:0] res_value;
  logic               hi_sel;
  logic               out_free;
  logic [HALF_W-1:0]  mul_b;
  logic [STATE_W-1:0] product;
  logic [HALF_W:0]    trial;
  logic               seed_pop;

  assign out_free = !m_tvalid || m_tready;
  assign seed_pop = (state == B_IDLE) && pop_valid && (pop_item.op == OP_SEED);
  assign mul_b    = hi_sel ? square_state[STATE_W-1:HALF_W] : square_state[HALF_W-1:0];
  assign product  = STATE_W'(square_state[HALF_W-1:0]) * STATE_W'(mul_b);
  assign sum_next = lo_prod + {cross_prod, {(STATE_W-VALUE_W){1'b0}}} + weyl_counter;

  always_comb begin
    trial = {2'b00, rem};
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {trial[HALF_W-1:0], dividend[STATE_W-1-i]};
      if (trial >= {2'b00, divisor}) begin
        trial = trial - {2'b00, divisor};
      end
    end
    rem_next = trial[VALUE_W-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop_valid && (pop_item.op != OP_SEED)) begin
          state_next = B_MUL_LO;
        end
      end
      B_MUL_LO: state_next = B_MUL_HI;
      B_MUL_HI: state_next = B_SUM;
      B_SUM:    state_next = bad_range ? B_OUT : B_DIV;
      B_DIV: begin
        if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    hi_sel = 1'b0;
    case (state)
      B_IDLE:   pop    = pop_valid;
      B_MUL_HI: hi_sel = 1'b1;
      default: begin
        pop    = 1'b0;
        hi_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      square_state <= '0;
      weyl_counter <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (seed_pop) begin
        square_state <= {pop_item.operand, pop_item.operand};
        weyl_counter <= '0;
      end
      if (state == B_MUL_LO) begin
        weyl_counter <= weyl_counter + WEYL_STEP;
      end
      if (state == B_SUM) begin
        square_state <= swap_halves(sum_next);
      end
      if (state == B_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        bad_range <= (pop_item.op == OP_DRAW_ERR);
        divisor   <= pop_item.operand[VALUE_W-1:0];
      end
      B_MUL_LO: lo_prod    <= product;
      B_MUL_HI: cross_prod <= product[VALUE_W-1:0];
      B_SUM: begin
        dividend  <= swap_halves(sum_next);
        rem       <= '0;
        div_cnt   <= '0;
        res_value <= '0;
      end
      B_DIV: begin
        dividend  <= {dividend[STATE_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
        rem       <= rem_next;
        div_cnt   <= div_cnt + 1'b1;
        res_value <= rem_next;
      end
      B_OUT: begin
        if (out_free) begin
          m_tdata <= {1'b0, res_value};
          m_tuser <= bad_range;
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  `ASSERT_PROP(a_err_value_zero, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == '0))
  `ASSERT_PROP(a_rem_below_divisor, clk, rst, (state == B_DIV) |-> (rem < divisor))
  `ASSERT_PROP(a_seed_clears_weyl, clk, rst, seed_pop |=> (weyl_counter == '0))

endmodule
`default_nettype wire

/* src/middle_square_weyl_random_top.sv */
// Top level of the middle-square Weyl random generator with range reduction.
// A draw passes the front slot, the queue and the back states MUL_LO, MUL_HI, SUM,
// DIV and OUT; a bad-range draw skips DIV. The back unit pops a new item only in IDLE,
// after the last is done; the radix-16 remainder takes 16 steps over the 64-bit state.
// Input is taken while the queue has room, also while a result waits at the output.
// Reset (rst, synchronous) clears the state, Weyl counter, queue and output valid.
`default_nettype none
module middle_square_weyl_random_top
  import msw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [2*HALF_W-1:0] s_tdata,   // seed_value, range_limit
  input  wire logic                s_tuser,   // mode
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [HALF_W-1:0]        m_tdata,   // value, zero pad bit
  output logic                     m_tuser    // range_error
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  msw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  msw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  msw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire
